/* hw/rtl/csa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_pkg
// Field widths and result status codes of the contiguous slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int OWNER_W  = 31;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;
    localparam int START_W  = 8;
    localparam int COUNT_W  = 9;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [OWNER_W-1:0]  owner_t;

    localparam status_t STATUS_DONE   = 2'd0;
    localparam status_t STATUS_NOROOM = 2'd1;
    localparam status_t STATUS_REJECT = 2'd2;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/csa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csa_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/contiguous_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_slot_allocator
// First-fit allocator of adjacent slots over an owner table held in RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the owner table to zero, one slot per cycle,
// with in_ready low until the sweep ends. A request is then worked on
// alone: the table is read one slot per cycle through the single RAM read
// port, whose read data is registered. An allocate scans from slot 0
// until the first free run of the asked length ends, then writes the owner
// into that run one slot per cycle. A release scans the whole table and
// clears matching slots in passing. Every result, also that of a rejected
// request, which skips the scan, waits in the finish state until the output
// register is free.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator #(
    parameter int SLOT_COUNT = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   mode,
    input  wire logic [csa_pkg::OWNER_W-1:0]  owner_id,
    input  wire logic [csa_pkg::LEN_W-1:0]    run_length,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [csa_pkg::STATUS_W-1:0] status,
    output logic [csa_pkg::START_W-1:0]  start_index,
    output logic [csa_pkg::COUNT_W-1:0]  occupied_count
);

    import csa_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [CW-1:0] LAST_SLOT = CW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] END_SLOT  = CW'(SLOT_COUNT);

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      addr_reg, addr_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic [CW-1:0]      run_reg, run_next;
    logic [AW-1:0]      first_reg, first_next;
    logic [CW-1:0]      left_reg, left_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic               mode_reg, mode_next;
    owner_t             owner_reg, owner_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    status_t            res_status_reg, res_status_next;
    logic [START_W-1:0] res_start_reg, res_start_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    owner_t        ram_wdata;
    owner_t        ram_rdata;
    logic [CW-1:0] run_inc;
    logic          in_fire;
    logic          scan_end;

    csa_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign in_fire        = in_valid && in_ready;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign start_index    = start_reg;
    assign occupied_count = count_reg;
    assign run_inc        = run_reg + CW'(1);
    assign scan_end       = !pend_reg && (addr_reg == END_SLOT);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        pend_next       = 1'b0;
        pidx_next       = addr_reg[AW-1:0];
        run_next        = run_reg;
        first_next      = first_reg;
        left_next       = left_reg;
        occ_next        = occ_reg;
        mode_next       = mode_reg;
        owner_next      = owner_reg;
        len_next        = len_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg[AW-1:0];
        ram_wdata       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + CW'(1);
                if (addr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next       = mode;
                    owner_next      = owner_id;
                    len_next        = run_length;
                    addr_next       = '0;
                    run_next        = '0;
                    res_status_next = STATUS_DONE;
                    res_start_next  = '0;
                    if (owner_id == '0 || (mode == MODE_ALLOC && run_length == '0))
                    begin
                        res_status_next = STATUS_REJECT;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read while the previous slot comes back
                if (addr_reg != END_SLOT)
                begin
                    addr_next = addr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (mode_reg == MODE_RELEASE)
                    begin
                        if (ram_rdata == owner_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_reg;
                            occ_next  = occ_reg - CW'(1);
                        end
                    end
                    else if (ram_rdata == '0)
                    begin
                        run_next = run_inc;
                        if (run_reg == '0)
                        begin
                            first_next = pidx_reg;
                        end
                        if (LW'(run_inc) == LW'(len_reg))
                        begin
                            // run found: tag it from its first slot
                            first_next     = (run_reg == '0) ? pidx_reg : first_reg;
                            res_start_next = START_W'((run_reg == '0) ? pidx_reg : first_reg);
                            left_next      = CW'(len_reg);
                            pend_next      = 1'b0;
                            state_next     = S_FILL;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (scan_end)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        res_status_next = STATUS_NOROOM;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = first_reg;
                ram_wdata  = owner_reg;
                first_next = first_reg + AW'(1);
                left_next  = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    occ_next   = occ_reg + CW'(len_reg);
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    start_next     = res_start_reg;
                    count_next     = COUNT_W'(occ_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        run_reg        <= run_next;
        first_reg      <= first_next;
        left_reg       <= left_next;
        mode_reg       <= mode_next;
        owner_reg      <= owner_next;
        len_reg        <= len_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        count_reg      <= count_next;
    end

endmodule

`default_nettype wire
